FILE: sv/ipv4p_pkg.sv
package ipv4p_pkg;

	// Default length limit: texts of this many characters or more fail
	localparam int MAX_TEXT_CHARS_DEF = 16;

	// Fixed field and state widths
	localparam int CH_W     = 8;
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 5;
	localparam int DOTS_W   = 2;
	localparam int DIGITS_W = 2;
	localparam int OCT_W    = 10;
	localparam int DONE_W   = 24;

	// Character codes and limits
	localparam logic [CH_W-1:0]     CH_DOT      = 8'h2E;
	localparam logic [CH_W-1:0]     CH_ZERO     = 8'h30;
	localparam logic [CH_W-1:0]     CH_NINE     = 8'h39;
	localparam logic [LEN_W-1:0]    LEN_SAT     = 5'd31;
	localparam logic [DOTS_W-1:0]   DOTS_FULL   = 2'd3;
	localparam logic [DIGITS_W-1:0] DIGITS_FULL = 2'd3;
	localparam logic [OCT_W-1:0]    OCTET_MAX   = 10'd255;

endpackage

FILE: sv/ipv4_dotted_decimal_parser.sv
// IPv4 dotted-decimal parser. Feed the address text one character per
// transfer on the slave side (character in s_tdata[7:0]) and close it with a
// transfer that has s_tlast set (its character is ignored). Each closing
// transfer yields one master-side transfer: m_tuser is 1 when the text was a
// well-formed dotted quad, and m_tdata then holds the address with the first
// octet in bits 31:24 (zero otherwise). Texts of MAX_TEXT_CHARS or more
// characters, characters other than digits and dots, octets of more than
// three digits or above 255, and dot counts other than three all fail; an
// empty octet reads as 0. The block takes one character per cycle unless
// the input is held as below; the whole per-character update of the
// counters and the multiply-by-ten is combinational between the input
// register and the state and result registers, where the closing transfer
// loads the result. The input keeps accepting while a result waits on
// m_tready, until a second closing transfer reaches the input register.
module ipv4_dotted_decimal_parser #(
	parameter int MAX_TEXT_CHARS = ipv4p_pkg::MAX_TEXT_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ipv4p_pkg::CH_W-1:0]   s_tdata,  // [7:0] ch
	input  logic                         s_tlast,  // end_of_string
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ipv4p_pkg::ADDR_W-1:0] m_tdata,  // [31:0] address
	output logic                         m_tuser   // [0] valid_res
);
	import ipv4p_pkg::*;

	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TEXT_CHARS);

	// Input stage
	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            last_s1;

	// Parse state
	logic [LEN_W-1:0]    text_length_q;
	logic [DOTS_W-1:0]   dot_count_q;
	logic [DIGITS_W-1:0] digit_count_q;
	logic [OCT_W-1:0]    octet_value_q;
	logic [DONE_W-1:0]   octets_done_q;
	logic                failed_q;

	// Result register
	logic              res_valid_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_ok_q;

	logic out_free;
	logic advance;

	logic is_dot;
	logic is_digit;
	logic [OCT_W-1:0] digit_val;
	logic [OCT_W-1:0] octet_next;
	logic ok;

	// Hold the input stage when its closing transfer has no free result slot
	assign out_free = !res_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	// Register incoming transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Classify the character and form the next octet value
	always_comb begin
		is_dot     = (ch_s1 == CH_DOT);
		is_digit   = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
		digit_val  = OCT_W'(ch_s1 - CH_ZERO);
		octet_next = (octet_value_q << 3) + (octet_value_q << 1) + digit_val;
		ok = !failed_q && (text_length_q < LEN_LIMIT) && (dot_count_q == DOTS_FULL)
			&& (octet_value_q <= OCTET_MAX);
	end

	// Advance the parse state; clear everything on the closing transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_length_q <= '0;
			dot_count_q   <= '0;
			digit_count_q <= '0;
			octet_value_q <= '0;
			octets_done_q <= '0;
			failed_q      <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				text_length_q <= '0;
				dot_count_q   <= '0;
				digit_count_q <= '0;
				octet_value_q <= '0;
				octets_done_q <= '0;
				failed_q      <= 1'b0;
			end else begin
				if (text_length_q != LEN_SAT) begin
					text_length_q <= text_length_q + 1'b1;
				end
				if (!failed_q) begin
					priority if (is_dot) begin
						if (dot_count_q == DOTS_FULL || octet_value_q > OCTET_MAX) begin
							failed_q <= 1'b1;
						end else begin
							dot_count_q   <= dot_count_q + 1'b1;
							octets_done_q <= {octets_done_q[DONE_W-9:0],
								octet_value_q[7:0]};
							octet_value_q <= '0;
							digit_count_q <= '0;
						end
					end else if (is_digit) begin
						if (digit_count_q == DIGITS_FULL) begin
							failed_q <= 1'b1;
						end else begin
							digit_count_q <= digit_count_q + 1'b1;
							octet_value_q <= octet_next;
						end
					end else begin
						failed_q <= 1'b1;
					end
				end
			end
		end
	end

	// Load the result on the closing transfer, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_ok_q   <= ok;
			res_addr_q <= ok ? {octets_done_q, octet_value_q[7:0]} : '0;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_addr_q;
	assign m_tuser  = res_ok_q;

endmodule
